### hw/rtl/aes_block_cipher_assert.svh
// Assertion macros shared by the cipher RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef AES_BLOCK_CIPHER_ASSERT_SVH
`define AES_BLOCK_CIPHER_ASSERT_SVH
// implication checked on every rising clock edge, held off during reset
`define AES_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define AES_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

### hw/rtl/aes_pkg.sv
// Package for the AES block cipher: constants, types, S-box and GF functions.
// Depends on nothing.
`default_nettype none
package aes_pkg;
   localparam int MaxRounds  = 14;
   localparam int StoreWords = 4 * (MaxRounds + 1);
   localparam int AddrW      = $clog2(StoreWords);
   localparam int RndW       = 4;

   localparam logic [2:0] CsrKeyLen = 3'd0;
   localparam logic [2:0] CsrRounds = 3'd1;
   localparam logic [2:0] CsrKey0   = 3'd2;
   localparam logic [2:0] CsrKey1   = 3'd3;
   localparam logic [2:0] CsrKey2   = 3'd4;
   localparam logic [2:0] CsrKey3   = 3'd5;

   localparam logic [7:0] GfPoly = 8'h1B;
   localparam logic [7:0] GfTop  = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXP_RD, ST_EXP_WR, ST_KEY_RD, ST_ROUND, ST_DONE
   } state_type;

   function automatic logic [7:0] gf_dbl(input logic [7:0] x);
      gf_dbl = {x[6:0], 1'b0} ^ (((x & GfTop) != 8'h00) ? GfPoly : 8'h00);
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      sbox = t[x];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      inv_sbox = t[x];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction
endpackage
`default_nettype wire

### hw/rtl/aes_stream_if.sv
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
`default_nettype none
interface aes_stream_if #(parameter type T = logic) ();
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/aes_round.sv
// Combinational AES round: one forward or inverse round on a 128-bit state.
// Depends on aes_pkg.
`default_nettype none
module aes_round
   import aes_pkg::*;
(
   input  wire logic         dec,
   input  wire logic         first,   // dec: key only; enc: key only
   input  wire logic         last,    // skip mix columns
   input  wire logic [127:0] state_in,
   input  wire logic [127:0] round_key,
   output logic [127:0]      state_out
);
   logic [7:0] s [16];
   logic [7:0] a [16];
   logic [7:0] b [16];
   logic [7:0] m [16];
   logic [127:0] keyed, fwd, inv;

   function automatic logic [7:0] mul(input logic [7:0] x, input logic [3:0] c);
      logic [7:0] x2, x4, x8;
      x2 = gf_dbl(x);
      x4 = gf_dbl(x2);
      x8 = gf_dbl(x4);
      mul = (c[0] ? x : 8'h00) ^ (c[1] ? x2 : 8'h00) ^ (c[2] ? x4 : 8'h00)
          ^ (c[3] ? x8 : 8'h00);
   endfunction

   always_comb begin
      for (int k = 0; k < 16; k++) s[k] = state_in[127 - 8*k -: 8];
      // forward: sub, shift, mix, then key
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            a[4*c + r] = sbox(s[4*((c + r) % 4) + r]);
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            m[4*c + r] = mul(a[4*c + r], 4'd2) ^ mul(a[4*c + (r+1)%4], 4'd3)
                       ^ a[4*c + (r+2)%4] ^ a[4*c + (r+3)%4];
      for (int k = 0; k < 16; k++) fwd[127 - 8*k -: 8] = last ? a[k] : m[k];
      // inverse: key, inv mix, inv shift, inv sub
      keyed = state_in ^ round_key;
      for (int k = 0; k < 16; k++) a[k] = keyed[127 - 8*k -: 8];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            m[4*c + r] = mul(a[4*c + r], 4'd14) ^ mul(a[4*c + (r+1)%4], 4'd11)
                       ^ mul(a[4*c + (r+2)%4], 4'd13) ^ mul(a[4*c + (r+3)%4], 4'd9);
      for (int k = 0; k < 16; k++) b[k] = last ? a[k] : m[k];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            inv[127 - 8*(4*((c + r) % 4) + r) -: 8] = inv_sbox(b[4*c + r]);
      if (first) state_out = state_in ^ round_key;
      else if (dec) state_out = inv;
      else state_out = fwd ^ round_key;
   end
endmodule
`default_nettype wire

### hw/rtl/aes_block_cipher.sv
// AES block cipher top level: key expansion into the round key RAM, round sequencer.
// Depends on aes_pkg, aes_stream_if, aes_round and aes_block_cipher_assert.svh.
//
// After any csr_ write the next block first expands the round keys into a
// 60-word RAM. The nk key words go in one per cycle; each further word is then
// read as word i-nk in ST_EXP_RD and written in ST_EXP_WR (word i-1 is kept in a
// register). Each block then takes rounds+1 key steps. A step reads its four
// key words through the one RAM read port and then applies one round. The
// result sits in an output register; a new block is taken once that register
// has been transferred.
`default_nettype none
`include "aes_block_cipher_assert.svh"
module aes_block_cipher
   import aes_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_result_high,
   output logic [63:0]      rsp_result_low
);
   typedef struct packed {
      logic         mode;
      logic [127:0] block;
   } req_type;

   aes_stream_if #(.T(req_type))      req_ch ();
   aes_stream_if #(.T(logic [127:0])) rsp_ch ();

   assign req_ch.valid = req_valid;
   assign req_ch.data  = {req_mode, req_block_high, req_block_low};
   assign req_ready    = req_ch.ready;
   assign rsp_valid       = rsp_ch.valid;
   assign rsp_result_high = rsp_ch.data[127:64];
   assign rsp_result_low  = rsp_ch.data[63:0];
   assign rsp_ch.ready    = rsp_ready;

   logic [3:0]  klen_ff, rnd_ff;
   logic [63:0] key_ff [4];
   logic        pend_ff, pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= 4'd4;
         rnd_ff  <= 4'd10;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CsrKeyLen: klen_ff <= csr_data[3:0];
            CsrRounds: rnd_ff  <= csr_data[3:0];
            CsrKey0:   key_ff[0] <= csr_data;
            CsrKey1:   key_ff[1] <= csr_data;
            CsrKey2:   key_ff[2] <= csr_data;
            CsrKey3:   key_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   logic [3:0] nk, nr;
   assign nk = (klen_ff < 4'd4) ? 4'd4 : ((klen_ff > 4'd8) ? 4'd8 : klen_ff);
   assign nr = (rnd_ff == 4'd0) ? 4'd1 :
               ((rnd_ff > 4'(MaxRounds)) ? 4'(MaxRounds) : rnd_ff);
   logic [AddrW-1:0] total;
   assign total = AddrW'({nr, 2'b00} + 6'd4);

   // round key RAM, one write and one read port, registered read
   logic [31:0]      ram [StoreWords];
   logic             we;
   logic [AddrW-1:0] waddr, raddr;
   logic [31:0]      wdata, rdata_ff;
   logic             rsel;
   logic [31:0]      prev_ff, prev_in;   // word i-1, kept in a register
   always_ff @(posedge clock) begin
      if (we) ram[waddr] <= wdata;
      rdata_ff <= ram[raddr];
   end

   state_type        st_ff, st_in;
   logic [AddrW-1:0] idx_ff, idx_in;     // expansion word index
   logic [3:0]       pos_ff, pos_in;     // idx mod nk
   logic [7:0]       rcon_ff, rcon_in;
   logic [RndW-1:0]  rk_ff, rk_in;       // round key number
   logic [1:0]       col_ff, col_in;
   logic [127:0]     key_acc_ff, key_acc_in;
   logic [127:0]     st128_ff, st128_in;
   logic             dec_ff, dec_in;
   logic [RndW-1:0]  step_ff, step_in;   // rounds applied so far
   logic             ov_ff, ov_in;
   logic [127:0]     res_ff, res_in;
   logic [127:0]     rnd_out;
   logic             rnd_first, rnd_last;

   aes_round u_round (
      .dec(dec_ff), .first(rnd_first), .last(rnd_last),
      .state_in(st128_ff), .round_key(key_acc_ff), .state_out(rnd_out));

   // decrypt starts with the short round and ends with the bare key add
   assign rnd_first = dec_ff ? (step_ff == nr) : (step_ff == '0);
   assign rnd_last  = dec_ff ? (step_ff == '0) : (step_ff == nr);

   logic [31:0] t_word, init_word;
   logic [63:0] kreg;
   always_comb begin
      kreg      = key_ff[idx_ff[2:1]];
      init_word = idx_ff[0] ? kreg[31:0] : kreg[63:32];
      t_word = prev_ff;
      if (pos_ff == 4'd0)
         t_word = sub_word({prev_ff[23:0], prev_ff[31:24]}) ^ {rcon_ff, 24'h0};
      else if (nk > 4'd6 && pos_ff == 4'd4)
         t_word = sub_word(prev_ff);
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE:   if (req_ch.valid && req_ch.ready)
                       st_in = pend_ff ? ST_EXP_RD : ST_KEY_RD;
         ST_EXP_RD: begin
            // schedule may be no longer than the key itself
            if (idx_ff < AddrW'(nk)) st_in = ST_EXP_RD;
            else if (idx_ff == total) st_in = ST_KEY_RD;
            else st_in = ST_EXP_WR;
         end
         ST_EXP_WR: st_in = (idx_ff + 1'b1 == total) ? ST_KEY_RD : ST_EXP_RD;
         ST_KEY_RD: if (col_ff == 2'd3 && rsel) st_in = ST_ROUND;
         ST_ROUND:  st_in = (step_ff == nr) ? ST_DONE : ST_KEY_RD;
         ST_DONE:   if (!ov_ff) st_in = ST_IDLE;
         default:   st_in = ST_IDLE;
      endcase
   end

   // rsel marks that the addressed key word is now in rdata_ff
   logic rsel_ff;
   assign rsel = rsel_ff;

   always_comb begin
      pend_in = pend_ff; idx_in = idx_ff; pos_in = pos_ff; rcon_in = rcon_ff;
      rk_in = rk_ff; col_in = col_ff; key_acc_in = key_acc_ff;
      st128_in = st128_ff; dec_in = dec_ff; step_in = step_ff;
      ov_in = ov_ff; res_in = res_ff; prev_in = prev_ff;
      we = 1'b0; waddr = idx_ff; wdata = init_word; raddr = idx_ff - AddrW'(nk);
      req_ch.ready = (st_ff == ST_IDLE) && !ov_ff;
      if (rsp_ch.valid && rsp_ch.ready) ov_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (req_ch.valid && req_ch.ready) begin
               dec_in = req_ch.data.mode;
               st128_in = req_ch.data.block;
               step_in = '0; col_in = '0;
               rk_in = req_ch.data.mode ? nr : '0;
               idx_in = '0; pos_in = '0; rcon_in = 8'h01;
            end
         end
         ST_EXP_RD: begin
            if (idx_ff < AddrW'(nk)) begin
               // copy key word straight in
               we = 1'b1; wdata = init_word; prev_in = init_word;
               idx_in = idx_ff + 1'b1;
               pos_in = (pos_ff + 1'b1 == nk) ? 4'd0 : pos_ff + 1'b1;
            end else if (idx_ff == total) begin
               pend_in = 1'b0;
            end
         end
         ST_EXP_WR: begin
            we = 1'b1; wdata = rdata_ff ^ t_word; prev_in = rdata_ff ^ t_word;
            if (pos_ff == 4'd0) rcon_in = gf_dbl(rcon_ff);
            idx_in = idx_ff + 1'b1;
            pos_in = (pos_ff + 1'b1 == nk) ? 4'd0 : pos_ff + 1'b1;
            if (idx_ff + 1'b1 == total) pend_in = 1'b0;
         end
         ST_KEY_RD: begin
            raddr = AddrW'({rk_ff, col_ff});
            if (rsel) begin
               key_acc_in[127 - 32*col_ff -: 32] = rdata_ff;
               col_in = col_ff + 1'b1;
            end
         end
         ST_ROUND: begin
            st128_in = rnd_out;
            step_in = step_ff + 1'b1;
            rk_in = dec_ff ? rk_ff - 1'b1 : rk_ff + 1'b1;
            if (step_ff == nr) begin
               res_in = rnd_out;
            end
         end
         ST_DONE: if (!ov_ff) ov_in = 1'b1;
         default: ;
      endcase
      if (csr_write) pend_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; pend_ff <= 1'b1; ov_ff <= 1'b0; rsel_ff <= 1'b0;
      end else begin
         st_ff <= st_in; pend_ff <= pend_in; ov_ff <= ov_in;
         rsel_ff <= (st_ff == ST_KEY_RD) && !rsel_ff;
      end
      idx_ff <= idx_in; pos_ff <= pos_in; rcon_ff <= rcon_in; rk_ff <= rk_in;
      col_ff <= col_in; key_acc_ff <= key_acc_in; st128_ff <= st128_in;
      dec_ff <= dec_in; step_ff <= step_in; res_ff <= res_in; prev_ff <= prev_in;
   end

   assign rsp_ch.valid = ov_ff;
   assign rsp_ch.data  = res_ff;

   `AES_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, st_ff == ST_IDLE && !ov_ff)
   `AES_ASSERT_NEXT(a_hold_rsp, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(res_ff))
   `AES_ASSERT_IMP(a_no_key_use_pending, clock, reset, st_ff == ST_ROUND, !pend_ff || csr_write)
endmodule
`default_nettype wire
